// File: rtl/cfl_pkg.sv
// Shared types, constants and rounding function for the complex FIR low-pass filter.
package cfl_pkg;

	localparam int TAPS     = 64;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int CIDX_W   = 6;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int ACC_W    = PROD_W + $clog2(TAPS);
	localparam int FRAC_W   = 15;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_COEF   = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] re;
		logic signed [SAMPLE_W-1:0] im;
	} cfl_iq_t;

	typedef struct packed {
		logic                    valid;
		logic signed [ACC_W-1:0] re;
		logic signed [ACC_W-1:0] im;
	} cfl_psum_t;

	typedef struct packed {
		logic shift;
		logic coef_we;
	} cfl_cell_ctl_t;

	// Shift right by FRAC_W with round-half-up, then saturate to the sample width.
	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W:0]        v;
		logic signed [ACC_W-FRAC_W:0] q;
		logic signed [SAMPLE_W-1:0]   r;
		v = (ACC_W+1)'(acc) + (ACC_W+1)'(1 <<< (FRAC_W - 1));
		q = (ACC_W-FRAC_W+1)'(v >>> FRAC_W);
		if (q > (ACC_W-FRAC_W+1)'((1 <<< (SAMPLE_W - 1)) - 1)) begin
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else if (q < -(ACC_W-FRAC_W+1)'(1 <<< (SAMPLE_W - 1))) begin
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			r = SAMPLE_W'(q);
		end
		return r;
	endfunction

endpackage

// File: rtl/cfl_cell.sv
// One filter tap: delay-line stage, coefficient, product and partial-sum stage.
module cfl_cell import cfl_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfl_cell_ctl_t            ctl,
	input  logic signed [COEF_W-1:0] coef_value,
	input  cfl_iq_t                  sample_in,
	output cfl_iq_t                  sample_out,
	input  cfl_psum_t                psum_in,
	output cfl_psum_t                psum_out
);

	cfl_iq_t                  sample_q;
	logic signed [COEF_W-1:0] coef_q;
	logic signed [PROD_W-1:0] prod_re_q;
	logic signed [PROD_W-1:0] prod_im_q;
	logic                     psum_v_q;
	logic signed [ACC_W-1:0]  psum_re_q;
	logic signed [ACC_W-1:0]  psum_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
			coef_q   <= '0;
		end else begin
			if (ctl.shift) begin
				sample_q <= sample_in;
			end
			if (ctl.coef_we) begin
				coef_q <= coef_value;
			end
		end
	end

	// Products are registered from the stored sample and coefficient.
	always_ff @(posedge clk) begin
		prod_re_q <= PROD_W'(sample_q.re * coef_q);
		prod_im_q <= PROD_W'(sample_q.im * coef_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_v_q <= 1'b0;
		end else begin
			psum_v_q <= psum_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		psum_re_q <= psum_in.re + ACC_W'(prod_re_q);
		psum_im_q <= psum_in.im + ACC_W'(prod_im_q);
	end

	assign sample_out = sample_q;
	assign psum_out   = {psum_v_q, psum_re_q, psum_im_q};

endmodule

// File: rtl/cfl_out_buf.sv
// Two-entry result buffer with rounding and saturation of the final sum.
module cfl_out_buf import cfl_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfl_psum_t                  res,
	output logic                       full,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_re,
	output logic signed [SAMPLE_W-1:0] out_im
);

	cfl_iq_t res_iq;
	cfl_iq_t out_q;
	cfl_iq_t skid_q;
	logic    out_v_q;
	logic    skid_v_q;
	logic    out_free;

	assign res_iq.re = round_sat(res.re);
	assign res_iq.im = round_sat(res.im);
	assign out_free  = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= res.valid;
			end else begin
				out_v_q  <= res.valid;
			end
		end else if (res.valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_v_q) begin
				out_q  <= skid_q;
				skid_q <= res_iq;
			end else begin
				out_q  <= res_iq;
			end
		end else if (res.valid) begin
			skid_q <= res_iq;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_re    = out_q.re;
	assign out_im    = out_q.im;

endmodule

// File: rtl/complex_fir_lowpass.sv
// Complex FIR low-pass filter: I/Q samples, real coefficients, one tap cell per coefficient.
//
// Each input transfer either loads one coefficient (action 1, does not make the filter busy,
// no result) or filters one sample (action 0). A sample shifts into a row of TAPS cells, each
// holding one delayed sample and one coefficient with its own multipliers; the partial sum
// then walks down the row one cell per cycle into the output buffer, and no next item is
// taken until the sum has left the last cell. All delay-line entries and coefficients reset
// to zero; coefficient indexes at or beyond TAPS are ignored. Results are rounded half-up
// from Q8.30 sums and saturated to Q1.15. A two-entry output buffer lets a new item enter
// while an earlier result is waiting.
module complex_fir_lowpass import cfl_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic signed [SAMPLE_W-1:0] sample_re,
	input  logic signed [SAMPLE_W-1:0] sample_im,
	input  logic        [CIDX_W-1:0]   coef_index,
	input  logic signed [COEF_W-1:0]   coef_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_re,
	output logic signed [SAMPLE_W-1:0] out_im
);

	cfl_iq_t       line [TAPS+1];
	cfl_psum_t     chain [TAPS+1];
	cfl_cell_ctl_t ctl [TAPS];
	logic [TAPS-1:0] token;
	logic          busy_q;
	logic          start_s1;
	logic          start_s2;
	logic          buf_full;
	logic          take;
	logic          take_sample;
	logic          take_coef;

	assign in_ready    = !busy_q && !buf_full;
	assign take        = in_valid && in_ready;
	assign take_sample = take && (action == ACT_SAMPLE);
	assign take_coef   = take && (action == ACT_COEF);

	assign line[0].re = sample_re;
	assign line[0].im = sample_im;

	assign chain[0] = {start_s2, {(2 * ACC_W){1'b0}}};

	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		assign ctl[k].shift   = take_sample;
		assign ctl[k].coef_we = take_coef && (int'(coef_index) == k);
		assign token[k]       = chain[k+1].valid;

		cfl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[k]),
			.coef_value (coef_value),
			.sample_in  (line[k]),
			.sample_out (line[k+1]),
			.psum_in    (chain[k]),
			.psum_out   (chain[k+1])
		);
	end

	// Hold off new items until the sum leaves the last cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			start_s1 <= 1'b0;
			start_s2 <= 1'b0;
		end else begin
			start_s1 <= take_sample;
			start_s2 <= start_s1;
			if (take_sample) begin
				busy_q <= 1'b1;
			end else if (chain[TAPS].valid) begin
				busy_q <= 1'b0;
			end
		end
	end

	cfl_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (chain[TAPS]),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_re    (out_re),
		.out_im    (out_im)
	);

	a_one_sum_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(token))
		else $error("more than one partial sum in the tap row");

	a_sample_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take_sample |=> busy_q)
		else $error("sample transfer did not start a sweep");

	a_sweep_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start_s1 || start_s2 || (token != '0)) |-> busy_q)
		else $error("partial sum moving while idle");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		chain[TAPS].valid |-> !buf_full)
		else $error("result arrived with output buffer full");

endmodule

// File: tb/complex_fir_lowpass_tb.sv
// Self-checking testbench for the complex FIR low-pass filter: directed table, then random traffic.
module complex_fir_lowpass_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cfl_pkg::*;

	localparam int N_RANDOM     = 533;
	localparam int HOLD_CYCLES  = 500;
	localparam int DRAIN_CYCLES = 2 * (TAPS + 3) + 20;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic                       act;
		logic signed [SAMPLE_W-1:0] s_re;
		logic signed [SAMPLE_W-1:0] s_im;
		logic        [CIDX_W-1:0]   c_idx;
		logic signed [COEF_W-1:0]   c_val;
		logic                       typed;
		logic signed [SAMPLE_W-1:0] e_re;
		logic signed [SAMPLE_W-1:0] e_im;
	} stim_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       action = ACT_SAMPLE;
	logic signed [SAMPLE_W-1:0] sample_re = '0;
	logic signed [SAMPLE_W-1:0] sample_im = '0;
	logic        [CIDX_W-1:0]   coef_index = '0;
	logic signed [COEF_W-1:0]   coef_value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] out_re;
	logic signed [SAMPLE_W-1:0] out_im;

	// filter state as the testbench sees it
	logic signed [COEF_W-1:0] coef_bank [TAPS];
	cfl_iq_t                  iq_history [TAPS];
	int unsigned              hist_head;
	cfl_iq_t                  expected_iq [$];

	logic calm = 1'b0;
	logic hold_req = 1'b0;
	int   fails = 0;
	int   n_samples = 0;
	int   n_coefs = 0;
	int   n_checked = 0;
	int   cycle_count = 0;

	// transfers with a typed-in result have typed set; the rest go through the predictor
	stim_row_t dir_rows [0:16] = '{
		'{ACT_SAMPLE, 1234, -5678, 0, 0, 1'b1, 0, 0},
		'{ACT_SAMPLE, 32767, -32768, 0, 0, 1'b1, 0, 0},
		'{ACT_COEF, 0, 0, 0, -32768, 1'b0, 0, 0},
		'{ACT_SAMPLE, -32768, -32768, 0, 0, 1'b1, 32767, 32767},
		'{ACT_SAMPLE, 32767, -32768, 0, 0, 1'b0, 0, 0},
		'{ACT_COEF, 0, 0, 63, 32767, 1'b0, 0, 0},
		'{ACT_COEF, 0, 0, 1, -32768, 1'b0, 0, 0},
		'{ACT_SAMPLE, 32767, 32767, 0, 0, 1'b0, 0, 0},
		'{ACT_SAMPLE, -32768, 0, 0, 0, 1'b0, 0, 0},
		'{ACT_COEF, -1, -1, 1, 0, 1'b0, 0, 0},
		'{ACT_COEF, 0, 0, 63, 0, 1'b0, 0, 0},
		'{ACT_COEF, 0, 0, 0, 16384, 1'b0, 0, 0},
		'{ACT_SAMPLE, 1, -1, 0, 0, 1'b1, 1, 0},
		'{ACT_SAMPLE, 3, -3, 0, 0, 1'b1, 2, -1},
		'{ACT_COEF, 0, 0, 0, 32767, 1'b0, 0, 0},
		'{ACT_COEF, 0, 0, 32, -1, 1'b0, 0, 0},
		'{ACT_SAMPLE, -1, 1, 63, -1, 1'b0, 0, 0}
	};

	complex_fir_lowpass dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.sample_re  (sample_re),
		.sample_im  (sample_im),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_re     (out_re),
		.out_im     (out_im)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// round half up from Q34.30 back to Q1.15, clamp to 16 bits
	function automatic logic signed [SAMPLE_W-1:0] q15_round_sat(input longint acc);
		longint q;
		q = (acc + 64'sd16384) >>> FRAC_W;
		if (q > 32767) begin
			q = 32767;
		end else if (q < -32768) begin
			q = -32768;
		end
		return SAMPLE_W'(q);
	endfunction

	function automatic bit filter_transfer(input stim_row_t row, output cfl_iq_t y);
		longint      acc_re;
		longint      acc_im;
		int unsigned slot;
		acc_re = 0;
		acc_im = 0;
		y = '0;
		if (row.act == ACT_COEF) begin
			if (int'(row.c_idx) < TAPS) begin
				coef_bank[row.c_idx] = row.c_val;
			end
			return 1'b0;
		end
		iq_history[hist_head].re = row.s_re;
		iq_history[hist_head].im = row.s_im;
		// newest sample pairs with tap 0
		for (int k = 0; k < TAPS; k++) begin
			slot = (hist_head + TAPS - k) % TAPS;
			acc_re += longint'(iq_history[slot].re) * longint'(coef_bank[k]);
			acc_im += longint'(iq_history[slot].im) * longint'(coef_bank[k]);
		end
		hist_head = (hist_head + 1) % TAPS;
		y.re = q15_round_sat(acc_re);
		y.im = q15_round_sat(acc_im);
		return 1'b1;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(19))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return '0;
			3: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// mostly small taps so outputs stay in range; some full scale to hit saturation
	function automatic logic signed [COEF_W-1:0] rand_coef();
		int v;
		case ($urandom_range(9))
			0, 1: v = int'($urandom);
			2, 3, 4: v = int'($urandom_range(16383)) - 8192;
			default: v = int'($urandom_range(2047)) - 1024;
		endcase
		return COEF_W'(v);
	endfunction

	function automatic stim_row_t rand_row();
		stim_row_t r;
		r = '0;
		r.act = ($urandom_range(99) < 25) ? ACT_COEF : ACT_SAMPLE;
		r.s_re = rand_sample();
		r.s_im = rand_sample();
		r.c_idx = CIDX_W'($urandom_range(TAPS - 1));
		r.c_val = rand_coef();
		return r;
	endfunction

	task automatic send_item(input stim_row_t row);
		cfl_iq_t y;
		if (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		in_valid   <= 1'b1;
		action     <= row.act;
		sample_re  <= row.s_re;
		sample_im  <= row.s_im;
		coef_index <= row.c_idx;
		coef_value <= row.c_val;
		do @(posedge clk); while (!in_ready);
		if (filter_transfer(row, y)) begin
			if (row.typed) begin
				y.re = row.e_re;
				y.im = row.e_im;
			end
			expected_iq.push_back(y);
			n_samples++;
		end else begin
			n_coefs++;
		end
	endtask

	initial begin
		for (int k = 0; k < TAPS; k++) begin
			coef_bank[k] = '0;
			iq_history[k] = '0;
		end
		hist_head = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i]);
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			calm <= (i >= 300 && i < 400);
			if (i == 150) begin
				hold_req <= 1'b1;
			end
			send_item(rand_row());
		end
		in_valid <= 1'b0;
		while (expected_iq.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d sample transfers and %0d coefficient writes, %0d outputs compared,",
			n_samples, n_coefs, n_checked);
		$display("with saturation, half-up rounding, delay-line wrap and a %0d-cycle output stall.",
			HOLD_CYCLES);
		if (fails == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// output side: compare each transfer, stall at random, hold off once for a long stretch
	initial begin
		cfl_iq_t exp_iq;
		int      hold_left;
		bit      held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				n_checked++;
				if (expected_iq.size() == 0) begin
					$error("unexpected output transfer: out_re %0d out_im %0d", out_re, out_im);
					fails++;
				end else begin
					exp_iq = expected_iq.pop_front();
					if (out_re !== exp_iq.re) begin
						$error("out_re expected %0d actual %0d", exp_iq.re, out_re);
						fails++;
					end
					if (out_im !== exp_iq.im) begin
						$error("out_im expected %0d actual %0d", exp_iq.im, out_im);
						fails++;
					end
				end
			end
			if (hold_req && !held) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 22);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d outputs outstanding", cycle_count,
				expected_iq.size());
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

// File: sim.f
rtl/cfl_pkg.sv
rtl/cfl_cell.sv
rtl/cfl_out_buf.sv
rtl/complex_fir_lowpass.sv
tb/complex_fir_lowpass_tb.sv
